FILE: rtl/video_bob_deinterlace_pixels_defines.svh
// ----------------------------------------------------------------------------
// bob deinterlace assertion macros
// shared assertion forms for the bob/weave deinterlace block
// ----------------------------------------------------------------------------
`ifndef VIDEO_BOB_DEINTERLACE_PIXELS_DEFINES_SVH
`define VIDEO_BOB_DEINTERLACE_PIXELS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, quiet during reset
`define VBD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bob deinterlace check failed");

// next-cycle implication, quiet during reset
`define VBD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bob deinterlace check failed");

`else

`define VBD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define VBD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/vbd_pkg.sv
// ----------------------------------------------------------------------------
// vbd_pkg
// types and constants shared by the bob/weave deinterlace block
// ----------------------------------------------------------------------------
package vbd_pkg;

  localparam int LANES      = 4;
  localparam int BUS_W      = 64;
  localparam int WORD_W     = 16;
  localparam int WORD_LANES = BUS_W / WORD_W;
  localparam int ACT_LANES  = (LANES < WORD_LANES) ? LANES : WORD_LANES;

  localparam int LUMA_W  = 7;
  localparam int DIFF_W  = LUMA_W + 1;
  localparam int SQ_SHIFT = 12;
  localparam int SQ_W    = WORD_W - SQ_SHIFT;

  localparam int EDGE_W   = 14;
  localparam int THRESH_W = 13;

  localparam logic [EDGE_W-1:0]   EDGE_RESET   = 14'd625;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 13'd73;

  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;

  // register index, taken from paddr[2]
  localparam logic REG_EDGE_WEIGHT      = 1'b0;
  localparam logic REG_JAGGIE_THRESHOLD = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [EDGE_W-1:0]   edge_weight;
    logic [THRESH_W-1:0] jaggie_threshold;
  } vbd_cfg_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } vbd_ctrl_t;

endpackage

FILE: rtl/vbd_in_if.sv
// ----------------------------------------------------------------------------
// vbd_in_if
// input channel: three lines of four yuy2 words with valid/ready
// ----------------------------------------------------------------------------
interface vbd_in_if
  import vbd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [BUS_W-1:0] line_above;
  logic [BUS_W-1:0] other_field_line;
  logic [BUS_W-1:0] line_below;

  modport source (output valid, output line_above, output other_field_line,
                  output line_below, input ready);
  modport sink   (input valid, input line_above, input other_field_line,
                  input line_below, output ready);
endinterface

FILE: rtl/vbd_out_if.sv
// ----------------------------------------------------------------------------
// vbd_out_if
// output channel: four deinterlaced yuy2 words with valid/ready
// ----------------------------------------------------------------------------
interface vbd_out_if
  import vbd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [BUS_W-1:0] output_pixels;

  modport source (output valid, output output_pixels, input ready);
  modport sink   (input valid, input output_pixels, output ready);
endinterface

FILE: rtl/vbd_cfg.sv
// ----------------------------------------------------------------------------
// vbd_cfg
// apb register file for edge weight and jaggie threshold
// ----------------------------------------------------------------------------
module vbd_cfg
  import vbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output vbd_cfg_t           cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_weight      <= EDGE_RESET;
      cfg.jaggie_threshold <= THRESH_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_EDGE_WEIGHT:      cfg.edge_weight      <= pwdata[EDGE_W-1:0];
        REG_JAGGIE_THRESHOLD: cfg.jaggie_threshold <= pwdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EDGE_WEIGHT:      prdata = PDATA_W'(cfg.edge_weight);
      REG_JAGGIE_THRESHOLD: prdata = PDATA_W'(cfg.jaggie_threshold);
      default:              prdata = '0;
    endcase
  end

endmodule

FILE: rtl/vbd_lane.sv
// ----------------------------------------------------------------------------
// vbd_lane
// one pixel lane: motion score and choice between average and weave
// ----------------------------------------------------------------------------
module vbd_lane
  import vbd_pkg::*;
(
  input  logic      clk,
  input  vbd_ctrl_t ctrl,
  input  vbd_cfg_t  cfg,
  input  word_t     above,
  input  word_t     other,
  input  word_t     below,
  output word_t     result
);

  logic signed [DIFF_W-1:0] d_above;
  logic signed [DIFF_W-1:0] d_below;
  logic signed [DIFF_W-1:0] d_vert;
  logic signed [WORD_W-1:0] prod_c;
  logic signed [WORD_W-1:0] dsq_c;
  word_t                    avg_c;

  // stage 1 registers
  logic [WORD_W-1:0] prod;
  logic [SQ_W-1:0]   sq;
  word_t             avg;
  word_t             weave;

  logic [SQ_W+EDGE_W-1:0] edge_full;
  logic [WORD_W-1:0]      score;
  logic                   use_avg;

  // luma is the low byte, halved
  assign d_above = $signed({1'b0, above[LUMA_W:1]}) - $signed({1'b0, other[LUMA_W:1]});
  assign d_below = $signed({1'b0, below[LUMA_W:1]}) - $signed({1'b0, other[LUMA_W:1]});
  assign d_vert  = $signed({1'b0, above[LUMA_W:1]}) - $signed({1'b0, below[LUMA_W:1]});
  assign prod_c  = WORD_W'(d_above) * WORD_W'(d_below);
  assign dsq_c   = WORD_W'(d_vert) * WORD_W'(d_vert);

  // bytewise halves summed, no carry crosses the byte boundary
  assign avg_c = {1'b0, above[WORD_W-1:9], 1'b0, above[LUMA_W:1]}
               + {1'b0, below[WORD_W-1:9], 1'b0, below[LUMA_W:1]};

  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      prod  <= prod_c;
      sq    <= dsq_c[WORD_W-1:SQ_SHIFT];
      avg   <= avg_c;
      weave <= other;
    end
  end

  // stage 2: edge penalty, wrap to 16 bits, signed compare
  assign edge_full = (SQ_W+EDGE_W)'(sq) * (SQ_W+EDGE_W)'(cfg.edge_weight);
  assign score     = prod - edge_full[WORD_W-1:0];
  assign use_avg   = $signed(score) > $signed(WORD_W'(cfg.jaggie_threshold));
  assign result    = use_avg ? avg : weave;

endmodule

FILE: rtl/vbd_merge.sv
// ----------------------------------------------------------------------------
// vbd_merge
// gathers the lane words into the output register
// ----------------------------------------------------------------------------
module vbd_merge
  import vbd_pkg::*;
(
  input  logic             clk,
  input  vbd_ctrl_t        ctrl,
  input  word_t            lane_word [ACT_LANES],
  output logic [BUS_W-1:0] pixels
);

  logic [BUS_W-1:0] pixels_next;

  always_comb begin
    pixels_next = '0;
    for (int i = 0; i < ACT_LANES; i++) begin
      pixels_next[i*WORD_W +: WORD_W] = lane_word[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s2_load) begin
      pixels <= pixels_next;
    end
  end

endmodule

FILE: rtl/video_bob_deinterlace_pixels.sv
// ----------------------------------------------------------------------------
// video_bob_deinterlace_pixels
// bob/weave deinterlace of four yuy2 pixels per item, one lane per word
// ----------------------------------------------------------------------------
// accepted input items pass the stage 1 registers, then the output register
// throughput: one item per cycle unless the output stalls, two-stage pipeline
// each stage has its own valid, so a stalled output still lets stage 1 fill
// reset: synchronous, active high; clears pipeline valids, loads edge weight
// 625 and jaggie threshold 73; payload registers are not reset
`include "video_bob_deinterlace_pixels_defines.svh"

module video_bob_deinterlace_pixels
  import vbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  vbd_in_if.sink             pix_in,
  vbd_out_if.source          pix_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  vbd_cfg_t  cfg;
  vbd_ctrl_t ctrl;

  logic s1_valid;
  logic out_valid;
  logic s1_ready;
  logic s2_ready;

  word_t lane_word [ACT_LANES];

  // register file
  vbd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // per-stage handshake: a stage takes new data when empty or when it drains
  assign s2_ready     = !out_valid || pix_out.ready;
  assign s1_ready     = !s1_valid || s2_ready;
  assign pix_in.ready = s1_ready;

  assign ctrl.s1_load = pix_in.valid && s1_ready;
  assign ctrl.s2_load = s1_valid && s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pix_in.valid;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  // the lanes, one per 16-bit word of the bus
  for (genvar i = 0; i < ACT_LANES; i++) begin : g_lane
    vbd_lane u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .cfg    (cfg),
      .above  (pix_in.line_above[i*WORD_W +: WORD_W]),
      .other  (pix_in.other_field_line[i*WORD_W +: WORD_W]),
      .below  (pix_in.line_below[i*WORD_W +: WORD_W]),
      .result (lane_word[i])
    );
  end

  // output register, words beyond the lane count read as zero
  vbd_merge u_merge (
    .clk       (clk),
    .ctrl      (ctrl),
    .lane_word (lane_word),
    .pixels    (pix_out.output_pixels)
  );

  assign pix_out.valid = out_valid;

  // accepted item is in stage 1 on the next cycle
  `VBD_ASSERT_NEXT(a_accept_fills_s1, clk, rst, pix_in.valid && pix_in.ready, s1_valid)
  // stage 1 moving on always presents a result next cycle
  `VBD_ASSERT_NEXT(a_s1_drains_to_out, clk, rst, s1_valid && s2_ready, pix_out.valid)
  // input is only held off when both stages are occupied
  `VBD_ASSERT_SAME(a_stall_only_full, clk, rst, !pix_in.ready, s1_valid && out_valid)

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bob/weave deinterlace testbench
// drives groups of three yuy2 lines through the deinterlacer with random
// gaps and output stalls, predicts every output item per lane, and checks
// the results in order across several edge weight and threshold settings
// ----------------------------------------------------------------------------
module testbench;
  import vbd_pkg::*;

  typedef struct packed {
    logic [BUS_W-1:0] above;
    logic [BUS_W-1:0] other;
    logic [BUS_W-1:0] below;
  } line_group_t;

  typedef logic [7:0] luma_row_t [WORD_LANES];

  logic clk = 1'b0;
  logic rst = 1'b1;

  // apb-style register port
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  vbd_in_if  pix_in_if ();
  vbd_out_if pix_out_if ();

  video_bob_deinterlace_pixels dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in_if),
    .pix_out (pix_out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // own copy of the two registers, updated when a write lands
  logic [EDGE_W-1:0]   model_edge_weight = EDGE_RESET;
  logic [THRESH_W-1:0] model_threshold   = THRESH_RESET;

  line_group_t      pending_lines [$];
  logic [BUS_W-1:0] expected_pixels [$];

  int  items_queued    = 0;
  int  items_taken     = 0;
  int  items_checked   = 0;
  int  lanes_averaged  = 0;
  int  lanes_woven     = 0;
  int  settings_used   = 0;
  int  errors          = 0;
  bit  idling_on       = 1'b1;
  bit  in_taken        = 1'b0;
  int  send_gap        = 0;
  int  recv_gap        = 0;

  // one lane: motion score against the threshold picks average or weave
  function automatic logic [WORD_W-1:0] deinterlace_word(
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] e,
    input  logic [WORD_W-1:0] b,
    output bit                averaged
  );
    logic [15:0] y1, ye, y2;
    logic [15:0] d1, d2, prod, dv, sq_full, sq, edge_term, score;
    y1 = {9'd0, a[7:1]};
    ye = {9'd0, e[7:1]};
    y2 = {9'd0, b[7:1]};
    // everything wraps at 16 bits as the hardware datapath does
    d1        = y1 - ye;
    d2        = y2 - ye;
    prod      = d1 * d2;
    dv        = y1 - y2;
    sq_full   = dv * dv;
    sq        = sq_full >> SQ_SHIFT;
    edge_term = sq * {2'b00, model_edge_weight};
    score     = prod - edge_term;
    averaged  = $signed(score) > $signed({3'b000, model_threshold});
    if (averaged) begin
      return {1'b0, a[15:9], 1'b0, a[7:1]} + {1'b0, b[15:9], 1'b0, b[7:1]};
    end
    return e;
  endfunction

  // full item: lanes past the configured count stay zero
  function automatic logic [BUS_W-1:0] deinterlace_group(input line_group_t g);
    logic [BUS_W-1:0] result;
    bit               avg;
    result = '0;
    for (int i = 0; i < WORD_LANES; i++) begin
      if (i < ACT_LANES) begin
        result[WORD_W*i +: WORD_W] = deinterlace_word(g.above[WORD_W*i +: WORD_W],
                                                      g.other[WORD_W*i +: WORD_W],
                                                      g.below[WORD_W*i +: WORD_W], avg);
        if (avg) lanes_averaged++;
        else lanes_woven++;
      end
    end
    return result;
  endfunction

  // lumas as given, chroma bytes random
  function automatic line_group_t make_group(input luma_row_t ya, input luma_row_t ye,
                                             input luma_row_t yb);
    line_group_t g;
    for (int i = 0; i < WORD_LANES; i++) begin
      g.above[WORD_W*i +: WORD_W] = {8'($urandom), ya[i]};
      g.other[WORD_W*i +: WORD_W] = {8'($urandom), ye[i]};
      g.below[WORD_W*i +: WORD_W] = {8'($urandom), yb[i]};
    end
    return g;
  endfunction

  function automatic logic [7:0] near_luma(input logic [7:0] base, input int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] extreme_luma();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      3: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // mix of fully random lanes and lanes with related lumas, so that both
  // the averaged and the woven branch come up often
  function automatic line_group_t random_group();
    luma_row_t ya, ye, yb;
    for (int i = 0; i < WORD_LANES; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          ya[i] = 8'($urandom);
          ye[i] = 8'($urandom);
          yb[i] = 8'($urandom);
        end
        1: begin
          ye[i] = 8'($urandom);
          ya[i] = near_luma(ye[i], 60);
          yb[i] = near_luma(ye[i], 60);
        end
        2: begin
          ya[i] = extreme_luma();
          ye[i] = extreme_luma();
          yb[i] = extreme_luma();
        end
        default: begin
          ya[i] = 8'($urandom);
          yb[i] = near_luma(ya[i], 20);
          ye[i] = 8'($urandom);
        end
      endcase
    end
    return make_group(ya, ye, yb);
  endfunction

  task automatic queue_group(input line_group_t g);
    pending_lines.push_back(g);
    items_queued++;
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_group(random_group());
  endtask

  // hold until every queued item went in and every result came back
  task automatic wait_drained();
    while (items_taken != items_queued || expected_pixels.size() != 0) @(posedge clk);
  endtask

  // write a register, then read it back; only the low bits are kept
  task automatic program_register(input logic idx, input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_EDGE_WEIGHT) model_edge_weight = data[EDGE_W-1:0];
    else model_threshold = data[THRESH_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (idx == REG_EDGE_WEIGHT) ? PDATA_W'(model_edge_weight)
                                    : PDATA_W'(model_threshold);
    if (prdata !== want) begin
      $error("register %0d readback: expected %h, actual %h", idx, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // input side: one item per handshake, random bursts of idle cycles
  always @(negedge clk) begin : drive_lines
    line_group_t g;
    if (rst) begin
      pix_in_if.valid <= 1'b0;
    end else if (!pix_in_if.valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap        <= send_gap - 1;
        pix_in_if.valid <= 1'b0;
      end else if (pending_lines.size() != 0 && idling_on && $urandom_range(0, 9) == 0) begin
        send_gap        <= $urandom_range(0, 14);
        pix_in_if.valid <= 1'b0;
      end else if (pending_lines.size() != 0) begin
        g = pending_lines.pop_front();
        pix_in_if.line_above       <= g.above;
        pix_in_if.other_field_line <= g.other;
        pix_in_if.line_below       <= g.below;
        pix_in_if.valid            <= 1'b1;
      end else begin
        pix_in_if.valid <= 1'b0;
      end
    end
  end

  // output side: ready drops in random bursts
  always @(negedge clk) begin
    if (rst) begin
      pix_out_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap         <= recv_gap - 1;
      pix_out_if.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      recv_gap         <= $urandom_range(0, 14);
      pix_out_if.ready <= 1'b0;
    end else begin
      pix_out_if.ready <= 1'b1;
    end
  end

  // checker at the rising edge: compare results first, then predict for the
  // item accepted at this same edge
  always @(posedge clk) begin : check_pixels
    logic [BUS_W-1:0] want;
    line_group_t      g;
    in_taken <= !rst && pix_in_if.valid && pix_in_if.ready;
    if (!rst && pix_out_if.valid && pix_out_if.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("output_pixels item with no expectation: %h", pix_out_if.output_pixels);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        items_checked++;
        if (pix_out_if.output_pixels !== want) begin
          $error("output_pixels mismatch: expected %h, actual %h",
                 want, pix_out_if.output_pixels);
          errors++;
        end
      end
    end
    if (!rst && pix_in_if.valid && pix_in_if.ready) begin
      g.above = pix_in_if.line_above;
      g.other = pix_in_if.other_field_line;
      g.below = pix_in_if.line_below;
      expected_pixels.push_back(deinterlace_group(g));
      items_taken++;
    end
  end

  // main sequence: phases of register settings, each drained before the next
  initial begin
    pix_in_if.valid            = 1'b0;
    pix_in_if.line_above       = '0;
    pix_in_if.other_field_line = '0;
    pix_in_if.line_below       = '0;
    pix_out_if.ready           = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // reset values: flat fields, saturated lumas, low luma bit dropped
    settings_used++;
    queue_group('{above: '0, other: '0, below: '0});
    queue_group('{above: '1, other: '1, below: '1});
    queue_group('{above: {4{16'haaaa}}, other: {4{16'h5555}}, below: {4{16'haaaa}}});
    queue_group('{above: {4{16'h5555}}, other: {4{16'haaaa}}, below: {4{16'h5555}}});
    queue_group('{above: '0, other: '1, below: '0});
    queue_group('{above: '1, other: '0, below: '1});
    // strong motion, pure edge, opposite-sign product, odd lumas
    queue_group(make_group('{8'd255, 8'd0, 8'd0, 8'd1},
                           '{8'd0, 8'd255, 8'd0, 8'd0},
                           '{8'd255, 8'd0, 8'd255, 8'd1}));
    queue_group(make_group('{8'd0, 8'd2, 8'd128, 8'd254},
                           '{8'd128, 8'd0, 8'd128, 8'd0},
                           '{8'd255, 8'd74, 8'd128, 8'd254}));
    queue_group(make_group('{8'd16, 8'd18, 8'd200, 8'd60},
                           '{8'd0, 8'd0, 8'd100, 8'd60},
                           '{8'd16, 8'd18, 8'd200, 8'd61}));
    queue_random(100);
    wait_drained();

    // no edge term, reset threshold: score sitting exactly on the threshold
    // weaves, one above it averages
    settings_used++;
    program_register(REG_EDGE_WEIGHT, 32'd0);
    queue_group(make_group('{8'd2, 8'd2, 8'd3, 8'd0},
                           '{8'd0, 8'd0, 8'd1, 8'd0},
                           '{8'd146, 8'd148, 8'd147, 8'd0}));
    queue_random(100);
    wait_drained();

    // all ones written: upper bits are dropped, both fields at maximum;
    // the edge product wraps and turns the score positive
    settings_used++;
    program_register(REG_EDGE_WEIGHT, 32'hffff_ffff);
    program_register(REG_JAGGIE_THRESHOLD, 32'hffff_ffff);
    queue_group(make_group('{8'd254, 8'd255, 8'd0, 8'd128},
                           '{8'd0, 8'd0, 8'd255, 8'd128},
                           '{8'd0, 8'd1, 8'd254, 8'd128}));
    queue_random(100);
    wait_drained();

    // top of the documented edge range, zero threshold
    settings_used++;
    program_register(REG_EDGE_WEIGHT, 32'd10000);
    program_register(REG_JAGGIE_THRESHOLD, 32'd0);
    queue_group(make_group('{8'd2, 8'd20, 8'd254, 8'd120},
                           '{8'd0, 8'd20, 8'd0, 8'd0},
                           '{8'd2, 8'd20, 8'd0, 8'd254}));
    queue_random(100);
    wait_drained();

    // random settings inside the documented ranges
    settings_used++;
    program_register(REG_EDGE_WEIGHT, $urandom_range(0, 10000));
    program_register(REG_JAGGIE_THRESHOLD, $urandom_range(0, 5000));
    queue_random(100);
    wait_drained();

    // back to the reset values, no idling on either side
    settings_used++;
    program_register(REG_EDGE_WEIGHT, 32'(EDGE_RESET));
    program_register(REG_JAGGIE_THRESHOLD, 32'(THRESH_RESET));
    idling_on = 1'b0;
    queue_random(100);
    wait_drained();

    // let any stray result surface past the two-stage pipeline
    repeat (10) @(posedge clk);
    $display("checked %0d items under %0d register settings", items_checked, settings_used);
    $display("lanes averaged %0d, lanes woven %0d", lanes_averaged, lanes_woven);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // overall watchdog
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
